### sv/fdc_pkg.sv
package fdc_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 24;
    localparam int DELAY_W  = 20;
    localparam int GAIN_W   = 16;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // configuration register indexes
    localparam logic REG_FEEDFORWARD = 1'b0;
    localparam logic REG_DAMPING     = 1'b1;

    // sequencer states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_LAST,
        S_COEF,
        S_H1M,
        S_H1A,
        S_H2M,
        S_H2A,
        S_H3M,
        S_H3A,
        S_VSAT,
        S_L1M,
        S_L2M,
        S_LACC,
        S_O1M,
        S_O2M,
        S_OACC,
        S_WR
    } state_t;

endpackage

### sv/fdc_ring.sv
module fdc_ring #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 24
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/fdc_mul.sv
module fdc_mul (
    input  logic                                clk,
    input  logic signed [fdc_pkg::MUL_A_W-1:0] a,
    input  logic signed [fdc_pkg::MUL_B_W-1:0] b,
    output logic signed [fdc_pkg::PROD_W-1:0]  p
);

    import fdc_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    // one signed multiply per cycle, product registered
    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

### sv/fractional_delay_comb_filter_top.sv
// Damped feedback comb filter with a Hermite-interpolated fractional delay.
// Input channel (in_valid/in_ready) carries sample_in, delay_fixed in
// 1/2^FRAC_BITS sample units and feedback_gain; output channel
// (out_valid/out_ready) returns one sample_out per input transaction.
// Configuration (cfg_we/cfg_index/cfg_data) writes feedforward_gain (0) and
// damping_coeff (1) at any time, but only while idle for defined results.
// One multiplier is shared by every product under a small sequencer: four
// ring reads, three Horner steps, two lowpass and two output products.
// The next input is taken only after the current item's result has been
// written to the ring and the sequencer is back in S_IDLE; the single
// multiplier and the single ring read port set this pace.
// After reset the ring is cleared to zero, one entry per cycle, from address
// 0 to DEPTH-1; in_ready stays low until that pass ends.
// The result waits in an output register; the block takes the next input
// meanwhile and stalls only at the ring write of the following result
// while out_ready is low.
module fractional_delay_comb_filter_top #(
    parameter int DEPTH     = 4096,
    parameter int FRAC_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [fdc_pkg::SAMPLE_W-1:0] sample_in,
    input  logic        [fdc_pkg::DELAY_W-1:0]  delay_fixed,
    input  logic        [fdc_pkg::GAIN_W-1:0]   feedback_gain,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [fdc_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic        [fdc_pkg::GAIN_W-1:0]   cfg_data
);

    import fdc_pkg::*;

    localparam int AW      = $clog2(DEPTH);
    localparam int ACC_W   = 32;
    localparam int SUM_W   = PROD_W + 1;
    localparam int CLAMP_W = 33;

    localparam logic [AW:0]          DEPTH_V   = (AW+1)'(DEPTH);
    localparam logic [AW-1:0]        LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CLAMP_W-1:0]   DLY_LO    = CLAMP_W'(1) << FRAC_BITS;
    localparam logic [CLAMP_W-1:0]   DLY_HI    = CLAMP_W'(DEPTH - 4) << FRAC_BITS;

    localparam logic signed [PROD_W-1:0] RND_F   = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W:0]    ONE_A   = (ACC_W+1)'(1);
    localparam logic signed [SUM_W-1:0]  RND_LP  = SUM_W'(1) << 15;
    localparam logic signed [SUM_W-1:0]  RND_OUT = SUM_W'(1) << 23;
    localparam logic signed [SUM_W-1:0]  S24_MAX = SUM_W'(24'sh7FFFFF);
    localparam logic signed [SUM_W-1:0]  S24_MIN = -SUM_W'(24'sh7FFFFF) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0]  S32_MAX = SUM_W'(32'sh7FFFFFFF);
    localparam logic signed [SUM_W-1:0]  S32_MIN = -SUM_W'(32'sh7FFFFFFF) - SUM_W'(1);

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v > S24_MAX)
        begin
            c = S24_MAX;
        end
        else if (v < S24_MIN)
        begin
            c = S24_MIN;
        end
        return c[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v > S32_MAX)
        begin
            c = S32_MAX;
        end
        else if (v < S32_MIN)
        begin
            c = S32_MIN;
        end
        return c[31:0];
    endfunction

    state_t state_reg, state_next;

    logic signed [GAIN_W-1:0]   ff_reg;
    logic        [GAIN_W-1:0]   damp_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic        [GAIN_W-1:0]   fb_reg;
    logic        [FRAC_BITS-1:0] f_reg;
    logic        [AW-1:0]       addr_reg;
    logic        [AW-1:0]       wr_idx_reg;
    logic        [AW-1:0]       clr_addr_reg;
    logic        [1:0]          tap_cnt_reg;
    logic                       cap_pend_reg;
    logic        [1:0]          cap_idx_reg;
    logic signed [SAMPLE_W-1:0] y_reg [4];
    logic signed [ACC_W-1:0]    c1_reg, c2_reg, c3_reg, acc_reg;
    logic signed [SAMPLE_W-1:0] v_reg;
    logic signed [31:0]         s_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SAMPLE_W-1:0] o_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;

    logic                       ring_we;
    logic        [AW-1:0]       ring_waddr;
    logic        [SAMPLE_W-1:0] ring_wdata;
    logic        [SAMPLE_W-1:0] ring_rdata;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;

    logic                       accept;
    logic                       wr_go;
    logic        [CLAMP_W-1:0]  dly_ext, dly_c;
    logic        [AW-1:0]       dly_int;
    logic        [AW:0]         start_diff;
    logic        [AW-1:0]       start_addr;
    logic signed [ACC_W-1:0]    ye0, ye1, ye2, ye3, d12;
    logic signed [PROD_W-1:0]   p_bias, p_shift;
    logic signed [ACC_W-1:0]    horner_c;
    logic signed [ACC_W:0]      acc_half;
    logic        [16:0]         damp_inv;
    logic signed [SUM_W-1:0]    prod_ext, lp_sum, lp_rnd, o_sum, o_rnd;

    assign accept = in_valid && in_ready;
    assign wr_go  = !out_valid_reg || out_ready;

    // shared units
    fdc_ring #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (SAMPLE_W)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (addr_reg),
        .rdata (ring_rdata)
    );

    fdc_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // delay clamp and first tap address
    always_comb
    begin
        dly_ext = CLAMP_W'(delay_fixed);
        dly_c   = dly_ext;
        if (dly_ext < DLY_LO)
        begin
            dly_c = DLY_LO;
        end
        else if (dly_ext > DLY_HI)
        begin
            dly_c = DLY_HI;
        end
        dly_int    = AW'(dly_c >> FRAC_BITS);
        start_diff = {1'b0, wr_idx_reg} - {1'b0, dly_int} - (AW+1)'(1);
        start_addr = start_diff[AW] ? AW'(start_diff + DEPTH_V) : start_diff[AW-1:0];
    end

    // tap arithmetic
    assign ye0 = ACC_W'(y_reg[0]);
    assign ye1 = ACC_W'(y_reg[1]);
    assign ye2 = ACC_W'(y_reg[2]);
    assign ye3 = ACC_W'(y_reg[3]);
    assign d12 = ye1 - ye2;

    // horner accumulate with rounding shift
    always_comb
    begin
        p_bias  = mul_p + RND_F;
        p_shift = p_bias >>> FRAC_BITS;
        case (state_reg)
            S_H1A:   horner_c = c2_reg;
            S_H2A:   horner_c = c1_reg;
            default: horner_c = ye1 <<< 1;
        endcase
    end

    // lowpass and output sums
    always_comb
    begin
        acc_half = ($signed({acc_reg[ACC_W-1], acc_reg}) + ONE_A) >>> 1;
        damp_inv = 17'h10000 - {1'b0, damp_reg};
        prod_ext = SUM_W'(mul_p);
        lp_sum   = sum_reg + prod_ext;
        lp_rnd   = (lp_sum + RND_LP) >>> 16;
        o_sum    = sum_reg + prod_ext;
        o_rnd    = (o_sum + RND_OUT) >>> 24;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_reg   <= 16'sd16384;
            damp_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FEEDFORWARD: ff_reg   <= signed'(cfg_data);
                REG_DAMPING:     damp_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_addr_reg == LAST_ADDR) state_next = S_IDLE;
            S_IDLE:  if (accept) state_next = S_RD;
            S_RD:    if (tap_cnt_reg == 2'd3) state_next = S_LAST;
            S_LAST:  state_next = S_COEF;
            S_COEF:  state_next = S_H1M;
            S_H1M:   state_next = S_H1A;
            S_H1A:   state_next = S_H2M;
            S_H2M:   state_next = S_H2A;
            S_H2A:   state_next = S_H3M;
            S_H3M:   state_next = S_H3A;
            S_H3A:   state_next = S_VSAT;
            S_VSAT:  state_next = S_L1M;
            S_L1M:   state_next = S_L2M;
            S_L2M:   state_next = S_LACC;
            S_LACC:  state_next = S_O1M;
            S_O1M:   state_next = S_O2M;
            S_O2M:   state_next = S_OACC;
            S_OACC:  state_next = S_WR;
            S_WR:    if (wr_go) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // sequencer outputs: ring write, multiplier operands, input ready
    always_comb
    begin
        in_ready   = 1'b0;
        ring_we    = 1'b0;
        ring_waddr = wr_idx_reg;
        ring_wdata = o_reg;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ring_we    = 1'b1;
                ring_waddr = clr_addr_reg;
                ring_wdata = '0;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_H1M:
            begin
                mul_a = MUL_A_W'(c3_reg);
                mul_b = MUL_B_W'(f_reg);
            end
            S_H2M, S_H3M:
            begin
                mul_a = MUL_A_W'(acc_reg);
                mul_b = MUL_B_W'(f_reg);
            end
            S_L1M:
            begin
                mul_a = MUL_A_W'(v_reg) <<< 8;
                mul_b = MUL_B_W'(damp_inv);
            end
            S_L2M:
            begin
                mul_a = MUL_A_W'(s_reg);
                mul_b = MUL_B_W'(damp_reg);
            end
            S_O1M:
            begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = MUL_B_W'(ff_reg);
            end
            S_O2M:
            begin
                mul_a = MUL_A_W'(s_reg);
                mul_b = MUL_B_W'(fb_reg);
            end
            S_WR:
            begin
                ring_we = wr_go;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control counters, ring pointers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            wr_idx_reg    <= '0;
            tap_cnt_reg   <= '0;
            cap_pend_reg  <= 1'b0;
            cap_idx_reg   <= '0;
            s_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_pend_reg <= (state_reg == S_RD);
            cap_idx_reg  <= tap_cnt_reg;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (accept)
            begin
                tap_cnt_reg <= '0;
            end
            else if (state_reg == S_RD)
            begin
                tap_cnt_reg <= tap_cnt_reg + 2'd1;
            end
            if (state_reg == S_LACC)
            begin
                s_reg <= sat32(lp_rnd);
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_WR && wr_go)
            begin
                wr_idx_reg    <= (wr_idx_reg == LAST_ADDR) ? '0 : wr_idx_reg + AW'(1);
                out_valid_reg <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= sample_in;
            fb_reg   <= feedback_gain;
            f_reg    <= dly_c[FRAC_BITS-1:0];
            addr_reg <= start_addr;
        end
        else if (state_reg == S_RD)
        begin
            addr_reg <= (addr_reg == LAST_ADDR) ? '0 : addr_reg + AW'(1);
        end
        if (cap_pend_reg)
        begin
            y_reg[cap_idx_reg] <= signed'(ring_rdata);
        end
        case (state_reg)
            S_COEF:
            begin
                c1_reg <= ye2 - ye0;
                c3_reg <= (ye3 - ye0) + (d12 <<< 1) + d12;
            end
            S_H1M:
            begin
                c2_reg <= (ye0 <<< 1) - (ye1 <<< 2) - ye1 + (ye2 <<< 2) - ye3;
            end
            S_H1A, S_H2A, S_H3A:
            begin
                acc_reg <= horner_c + ACC_W'(p_shift);
            end
            S_VSAT:
            begin
                v_reg <= sat24(SUM_W'(acc_half));
            end
            S_L2M:
            begin
                sum_reg <= prod_ext;
            end
            S_O2M:
            begin
                sum_reg <= prod_ext <<< 10;
            end
            S_OACC:
            begin
                o_reg <= sat24(o_rnd);
            end
            S_WR:
            begin
                if (wr_go)
                begin
                    sample_out_reg <= o_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule
